FILE: rtl/rrts_pkg.sv
// shared types and constants of the round-robin task scheduler
package rrts_pkg;

   localparam int DEF_TASK_COUNT = 16;
   localparam int DEF_IDLE_TASK  = 1;
   localparam int MAX_TASKS      = 16;
   localparam int CMD_FIFO_DEPTH = 2;

   localparam logic [7:0] PRIO_RESET = 8'd31;

   typedef enum logic [1:0] {
      KIND_CREATE  = 2'd0,
      KIND_BLOCK   = 2'd1,
      KIND_UNBLOCK = 2'd2,
      KIND_YIELD   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      OP_CREATE  = 3'd0,
      OP_BLOCK   = 3'd1,
      OP_UNBLOCK = 3'd2,
      OP_YIELD   = 3'd3,
      OP_REJECT  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      TS_UNUSED  = 3'd0,
      TS_RUNNING = 3'd1,
      TS_READY   = 3'd2,
      TS_BLOCKED = 3'd3,
      TS_WAITING = 3'd4,
      TS_HANGING = 3'd5
   } task_state_type;

   typedef enum logic [2:0] {
      ERR_OK            = 3'd0,
      ERR_NOT_BLOCKED   = 3'd1,
      ERR_LIVE          = 3'd2,
      ERR_NONE_RUNNABLE = 3'd3,
      ERR_BAD_STATUS    = 3'd4
   } err_type;

   typedef struct packed {
      op_type         op;
      logic [3:0]     task_id;
      logic [7:0]     prio;
      task_state_type hold_state;
      err_type        err;
   } cmd_type;

endpackage

FILE: rtl/rrts_front.sv
// front end: takes request beats, checks them and turns them into commands
module rrts_front #(
   parameter int TASK_COUNT = rrts_pkg::DEF_TASK_COUNT
) (
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_kind,
   input  logic [3:0]       req_task_id,
   input  logic [7:0]       req_priority_req,
   input  logic [1:0]       req_block_status,
   input  logic             fifo_full,
   output logic             push,
   output rrts_pkg::cmd_type push_cmd
);
   import rrts_pkg::*;

   logic tid_ok;

   assign req_stall = fifo_full;
   assign push      = req_valid && !fifo_full;
   assign tid_ok    = int'(req_task_id) < TASK_COUNT;

   always_comb begin
      push_cmd            = '0;
      push_cmd.task_id    = req_task_id;
      push_cmd.prio       = req_priority_req;
      push_cmd.hold_state = TS_BLOCKED;
      push_cmd.err        = ERR_OK;
      unique case (kind_type'(req_kind))
         KIND_CREATE: begin
            push_cmd.op = OP_CREATE;
            if (!tid_ok) begin
               push_cmd.op  = OP_REJECT;
               push_cmd.err = ERR_LIVE;
            end
         end
         KIND_UNBLOCK: begin
            push_cmd.op = OP_UNBLOCK;
            if (!tid_ok) begin
               push_cmd.op  = OP_REJECT;
               push_cmd.err = ERR_NOT_BLOCKED;
            end
         end
         KIND_BLOCK: begin
            push_cmd.op = OP_BLOCK;
            unique case (req_block_status)
               2'd0: push_cmd.hold_state = TS_BLOCKED;
               2'd1: push_cmd.hold_state = TS_WAITING;
               2'd2: push_cmd.hold_state = TS_HANGING;
               default: begin
                  push_cmd.op  = OP_REJECT;
                  push_cmd.err = ERR_BAD_STATUS;
               end
            endcase
         end
         KIND_YIELD: push_cmd.op = OP_YIELD;
         default:    push_cmd.op = OP_REJECT;
      endcase
   end

endmodule

FILE: rtl/rrts_cmd_fifo.sv
// short command queue between the front end and the scheduling core
module rrts_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rrts_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output rrts_pkg::cmd_type head_cmd
);
   import rrts_pkg::*;

   localparam int PW = $clog2(CMD_FIFO_DEPTH);
   localparam int FW = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type         slots_ff [CMD_FIFO_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]   fill_ff, fill_in;

   assign full       = fill_ff == FW'(CMD_FIFO_DEPTH);
   assign head_valid = fill_ff != '0;
   assign head_cmd   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/rrts_back.sv
// scheduling core: status, priority and ready deque tables plus the reply register
module rrts_back #(
   parameter int TASK_COUNT = rrts_pkg::DEF_TASK_COUNT,
   parameter int IDLE_TASK  = rrts_pkg::DEF_IDLE_TASK
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  rrts_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_running_task,
   output logic [7:0]        rsp_time_slice,
   output logic              rsp_switched,
   output logic [2:0]        rsp_error_code
);
   import rrts_pkg::*;

   localparam int TBL_DEPTH = (TASK_COUNT < MAX_TASKS) ? TASK_COUNT : MAX_TASKS;
   localparam int TW        = $clog2(TBL_DEPTH);
   localparam int CW        = $clog2(TBL_DEPTH + 1);
   localparam int IDLE_IDX  = IDLE_TASK % TASK_COUNT;
   localparam logic [TW-1:0] IDLE_ID   = TW'(IDLE_IDX);
   localparam logic [TW-1:0] LAST_SLOT = TW'(TBL_DEPTH - 1);
   localparam logic [TW:0]   DEPTH_W   = (TW + 1)'(TBL_DEPTH);

   typedef enum logic [1:0] {
      SCH_EXEC  = 2'b01,
      SCH_GRANT = 2'b10
   } sched_state_type;

   sched_state_type state_ff, state_in;

   task_state_type status_ff [TBL_DEPTH];
   task_state_type status_in [TBL_DEPTH];
   logic [7:0]     prio_ff   [TBL_DEPTH];
   logic [7:0]     prio_in   [TBL_DEPTH];
   logic [TW-1:0]  queue_ff  [TBL_DEPTH];
   logic [TW-1:0]  queue_in  [TBL_DEPTH];
   logic [TW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [TW-1:0]  current_ff, current_in;
   logic           sw_ff, sw_in;
   err_type        err_ff, err_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [3:0]     rsp_task_ff;
   logic [7:0]     rsp_slice_ff;
   logic           rsp_sw_ff;
   err_type        rsp_err_ff;

   logic           exec_go;
   logic           load;
   logic [TW-1:0]  tid;
   task_state_type tid_state;
   task_state_type idle_state;
   logic [TW-1:0]  head_task;
   logic [TW-1:0]  head_inc;
   logic [TW-1:0]  head_dec;
   logic [TW:0]    tail_sum;
   logic [TW-1:0]  tail;
   logic           queue_empty;
   logic           queue_full;

   function automatic logic is_held(task_state_type s);
      return s == TS_BLOCKED || s == TS_WAITING || s == TS_HANGING;
   endfunction

   assign exec_go     = (state_ff == SCH_EXEC) && cmd_valid;
   assign cmd_pop     = exec_go;
   assign load        = (state_ff == SCH_GRANT) && (!rsp_valid_ff || !rsp_stall);
   assign tid         = cmd.task_id[TW-1:0];
   assign tid_state   = status_ff[tid];
   assign idle_state  = status_ff[IDLE_ID];
   assign head_task   = queue_ff[head_ff];
   assign head_inc    = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign head_dec    = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
   assign tail_sum    = (TW + 1)'(head_ff) + (TW + 1)'(count_ff);
   assign tail        = (tail_sum >= DEPTH_W) ? TW'(tail_sum - DEPTH_W) : tail_sum[TW-1:0];
   assign queue_empty = count_ff == '0;
   assign queue_full  = count_ff == CW'(TBL_DEPTH);

   always_comb begin
      status_in  = status_ff;
      prio_in    = prio_ff;
      queue_in   = queue_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      current_in = current_ff;
      sw_in      = sw_ff;
      err_in     = err_ff;
      if (exec_go) begin
         sw_in  = 1'b0;
         err_in = ERR_OK;
         unique case (cmd.op)
            OP_CREATE: begin
               if (tid_state != TS_UNUSED) begin
                  err_in = ERR_LIVE;
               end else begin
                  status_in[tid] = TS_READY;
                  prio_in[tid]   = cmd.prio;
                  if (!queue_full) begin
                     queue_in[tail] = tid;
                     count_in       = count_ff + 1'b1;
                  end
               end
            end
            OP_UNBLOCK: begin
               if (!is_held(tid_state)) begin
                  err_in = ERR_NOT_BLOCKED;
               end else begin
                  status_in[tid] = TS_READY;
                  if (!queue_full) begin
                     queue_in[head_dec] = tid;
                     head_in            = head_dec;
                     count_in           = count_ff + 1'b1;
                  end
               end
            end
            OP_BLOCK: begin
               if (!queue_empty) begin
                  status_in[current_ff] = cmd.hold_state;
                  status_in[head_task]  = TS_RUNNING;
                  current_in            = head_task;
                  head_in               = head_inc;
                  count_in              = count_ff - 1'b1;
                  sw_in                 = 1'b1;
               end else if (IDLE_ID == current_ff || is_held(idle_state)) begin
                  status_in[current_ff] = cmd.hold_state;
                  status_in[IDLE_ID]    = TS_RUNNING;
                  current_in            = IDLE_ID;
                  sw_in                 = 1'b1;
               end else begin
                  err_in = ERR_NONE_RUNNABLE;
               end
            end
            OP_YIELD: begin
               sw_in = 1'b1;
               if (!queue_empty) begin
                  queue_in[tail]        = current_ff;
                  status_in[current_ff] = TS_READY;
                  status_in[head_task]  = TS_RUNNING;
                  current_in            = head_task;
                  head_in               = head_inc;
               end
            end
            OP_REJECT: err_in = cmd.err;
            default:   err_in = cmd.err;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SCH_EXEC:  if (exec_go) state_in = SCH_GRANT;
         SCH_GRANT: if (load) state_in = SCH_EXEC;
         default:   state_in = SCH_EXEC;
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SCH_EXEC;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         count_ff     <= (IDLE_IDX != 0) ? CW'(1) : '0;
         current_ff   <= '0;
         for (int i = 0; i < TBL_DEPTH; i++) begin
            queue_ff[i] <= IDLE_ID;
            if (i == 0) begin
               status_ff[i] <= TS_RUNNING;
               prio_ff[i]   <= PRIO_RESET;
            end else if (i == IDLE_IDX) begin
               status_ff[i] <= TS_READY;
               prio_ff[i]   <= PRIO_RESET;
            end else begin
               status_ff[i] <= TS_UNUSED;
               prio_ff[i]   <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         current_ff   <= current_in;
         status_ff    <= status_in;
         prio_ff      <= prio_in;
         queue_ff     <= queue_in;
      end
   end

   always_ff @(posedge clock) begin
      sw_ff  <= sw_in;
      err_ff <= err_in;
      if (load) begin
         rsp_task_ff  <= 4'(current_ff);
         rsp_slice_ff <= prio_ff[current_ff];
         rsp_sw_ff    <= sw_ff;
         rsp_err_ff   <= err_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_task = rsp_task_ff;
   assign rsp_time_slice   = rsp_slice_ff;
   assign rsp_switched     = rsp_sw_ff;
   assign rsp_error_code   = rsp_err_ff;

endmodule

FILE: rtl/round_robin_task_scheduler.sv
// Round-robin task scheduler: one reply beat for every event beat (create, block, unblock,
// yield). In the scheduling core, the exec state updates the status, priority and ready
// deque tables from the head of the command queue, and the grant state loads the reply
// register with the running task and its priority; the front end keeps taking up to two
// events ahead of the core, and a stalled reply holds the core only in its grant state.
// Tables come out of reset holding task 0 running and the idle task ready, with no clearing
// pass. Tasks at or above the smaller of TASK_COUNT and 16 can never be created.
module round_robin_task_scheduler #(
   parameter int TASK_COUNT = rrts_pkg::DEF_TASK_COUNT,
   parameter int IDLE_TASK  = rrts_pkg::DEF_IDLE_TASK
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [3:0] req_task_id,
   input  logic [7:0] req_priority_req,
   input  logic [1:0] req_block_status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_running_task,
   output logic [7:0] rsp_time_slice,
   output logic       rsp_switched,
   output logic [2:0] rsp_error_code
);
   import rrts_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    fifo_full;
   logic    cmd_pop;
   logic    cmd_valid;
   cmd_type cmd;

   rrts_front #(
      .TASK_COUNT(TASK_COUNT)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_task_id     (req_task_id),
      .req_priority_req(req_priority_req),
      .req_block_status(req_block_status),
      .fifo_full       (fifo_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   rrts_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (fifo_full),
      .pop       (cmd_pop),
      .head_valid(cmd_valid),
      .head_cmd  (cmd)
   );

   rrts_back #(
      .TASK_COUNT(TASK_COUNT),
      .IDLE_TASK (IDLE_TASK)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_running_task(rsp_running_task),
      .rsp_time_slice  (rsp_time_slice),
      .rsp_switched    (rsp_switched),
      .rsp_error_code  (rsp_error_code)
   );

endmodule
